// ===== sv/spq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants of the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int PRIO_W   = 8;
    localparam int BYTE_W   = 8;
    localparam int FILL_W   = 5;
    localparam int STAT_W   = 2;

    typedef enum logic {
        OP_ENQ = 1'b0,
        OP_DEQ = 1'b1
    } opcode_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        logic [PRIO_W-1:0] prio;
        logic [BYTE_W-1:0] tbyte;
    } entry_t;

    // Broadcast to every cell at once.
    typedef struct packed {
        logic   insert;
        logic   remove;
        entry_t entry;
    } cell_cmd_t;

endpackage : spq_pkg
`default_nettype wire

// ===== sv/spq_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain: keeps, takes the new entry, or shifts.
// ----------------------------------------------------------------------------
module spq_cell (
    input  wire                       aclk,
    input  wire                       occupied,
    input  spq_pkg::cell_cmd_t        cmd,
    input  wire                       left_ge,
    input  spq_pkg::entry_t           left_entry,
    input  spq_pkg::entry_t           right_entry,
    output logic                      ge,
    output spq_pkg::entry_t           entry
);

    spq_pkg::entry_t entry_reg;
    spq_pkg::entry_t entry_next;

    // Entry stays ahead of the new one (equal priority stays ahead).
    assign ge    = occupied && (entry_reg.prio >= cmd.entry.prio);
    assign entry = entry_reg;

    always_comb begin
        entry_next = entry_reg;
        priority if (cmd.insert && !ge) begin
            if (left_ge) begin
                entry_next = cmd.entry;
            end else begin
                entry_next = left_entry;
            end
        end else if (cmd.remove) begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

endmodule : spq_cell
`default_nettype wire

// ===== sv/sorted_priority_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Bounded priority queue built as a chain of sorting cells.
// ----------------------------------------------------------------------------
// Usage:
//   Input transfers carry a command in s_axis_tuser (0 enqueue, 1 dequeue);
//   an enqueue brings priority and task byte in s_axis_tdata. Every input
//   transfer yields exactly one result transfer on the m_axis side with the
//   dequeued byte, the fill level and a status (ok, empty, full).
//   All cells compare against the incoming priority at once and shift in
//   the same cycle, so one transfer is taken per cycle while the output is
//   not stalled; the result is registered and appears in the cycle after acceptance.
//   Throughput 1 item per cycle while m_axis_tready is high.
//   When the receiver stalls, the held result blocks s_axis_tready; the
//   next item is taken in the cycle the held result is transferred.
//   Equal priorities leave first in, first out. A full enqueue is dropped,
//   an empty dequeue returns byte 0.
//   Reset (aresetn low, synchronous) empties the queue and clears the
//   output valid; slot contents are not cleared.
// ----------------------------------------------------------------------------
module sorted_priority_queue (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [15:0] s_axis_tdata,  // [7:0] task_priority, [15:8] task_byte
    input  wire  [0:0]  s_axis_tuser,  // [0] opcode
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [15:0] m_axis_tdata,  // [7:0] out_byte, [12:8] fill_level
    output logic [1:0]  m_axis_tuser   // [1:0] status
);

    localparam int CAP = spq_pkg::CAPACITY;
    localparam int CW  = spq_pkg::CNT_W;
    localparam int FW  = spq_pkg::FILL_W;

    logic                     accept;
    logic                     full;
    logic                     empty;
    logic                     enq_ok;
    logic                     deq_ok;
    spq_pkg::opcode_t         opcode;
    spq_pkg::cell_cmd_t       cmd;
    logic [CAP-1:0]           occ;
    logic [CAP-1:0]           ge;
    spq_pkg::entry_t          cell_entry [CAP];

    logic [CW-1:0]            count_reg;
    logic [CW-1:0]            count_next;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic [spq_pkg::BYTE_W-1:0] out_byte_reg;
    logic [spq_pkg::BYTE_W-1:0] out_byte_next;
    spq_pkg::status_t         status_reg;
    spq_pkg::status_t         status_next;
    logic [FW-1:0]            fill_reg;
    logic [FW-1:0]            fill_next;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign opcode        = spq_pkg::opcode_t'(s_axis_tuser[0]);
    assign full          = (count_reg == CW'(CAP));
    assign empty         = (count_reg == '0);
    assign enq_ok        = accept && (opcode == spq_pkg::OP_ENQ) && !full;
    assign deq_ok        = accept && (opcode == spq_pkg::OP_DEQ) && !empty;

    assign cmd.insert      = enq_ok;
    assign cmd.remove      = deq_ok;
    assign cmd.entry.prio  = s_axis_tdata[7:0];
    assign cmd.entry.tbyte = s_axis_tdata[15:8];

    genvar gi;
    generate
        for (gi = 0; gi < CAP; gi++) begin : g_cell
            spq_pkg::entry_t left_e;
            spq_pkg::entry_t right_e;
            logic            left_g;

            assign occ[gi] = (count_reg > CW'(gi));

            if (gi == 0) begin : g_head
                assign left_g = 1'b1;
                assign left_e = cmd.entry;
            end else begin : g_mid
                assign left_g = ge[gi-1];
                assign left_e = cell_entry[gi-1];
            end

            if (gi == CAP - 1) begin : g_tail
                assign right_e = cell_entry[gi];
            end else begin : g_body
                assign right_e = cell_entry[gi+1];
            end

            spq_cell u_cell (
                .aclk        (aclk),
                .occupied    (occ[gi]),
                .cmd         (cmd),
                .left_ge     (left_g),
                .left_entry  (left_e),
                .right_entry (right_e),
                .ge          (ge[gi]),
                .entry       (cell_entry[gi])
            );
        end
    endgenerate

    always_comb begin
        count_next = count_reg;
        if (enq_ok) begin
            count_next = count_reg + CW'(1);
        end else if (deq_ok) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        status_next    = status_reg;
        fill_next      = fill_reg;
        if (accept) begin
            out_valid_next = 1'b1;
            out_byte_next  = deq_ok ? cell_entry[0].tbyte : '0;
            fill_next      = FW'(count_next);
            unique case (opcode)
                spq_pkg::OP_ENQ: status_next = full  ? spq_pkg::ST_FULL  : spq_pkg::ST_OK;
                spq_pkg::OP_DEQ: status_next = empty ? spq_pkg::ST_EMPTY : spq_pkg::ST_OK;
                default:         status_next = spq_pkg::ST_OK;
            endcase
        end else if (m_axis_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_byte_reg <= out_byte_next;
        status_reg   <= status_next;
        fill_reg     <= fill_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000, fill_reg, out_byte_reg};
    assign m_axis_tuser  = status_reg;

endmodule : sorted_priority_queue
`default_nettype wire

// ===== sv/spq_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spq_checker
// Port-level checks of the sorted priority queue, bound to the top level.
// ----------------------------------------------------------------------------
module spq_checker (
    input  wire        aclk,
    input  wire        aresetn,
    input  wire        s_axis_tvalid,
    input  wire        s_axis_tready,
    input  wire        m_axis_tvalid,
    input  wire        m_axis_tready,
    input  wire [15:0] m_axis_tdata,
    input  wire [1:0]  m_axis_tuser
);

    localparam logic [spq_pkg::FILL_W-1:0] FILL_CAP = spq_pkg::FILL_W'(spq_pkg::CAPACITY);

    // every accepted item shows its result in the next cycle
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_axis_tvalid && s_axis_tready) |=> m_axis_tvalid)
        else $error("result missing after accepted transfer");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("stalled result changed");

    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && (m_axis_tuser == spq_pkg::ST_EMPTY)) |->
            ((m_axis_tdata[7:0] == 8'd0) && (m_axis_tdata[12:8] == 5'd0)))
        else $error("empty status with nonzero byte or level");

    a_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && (m_axis_tuser == spq_pkg::ST_FULL)) |->
            ((m_axis_tdata[7:0] == 8'd0) && (m_axis_tdata[12:8] == FILL_CAP)))
        else $error("full status with wrong byte or level");

endmodule : spq_checker

bind sorted_priority_queue spq_checker u_spq_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire

// ===== bench/sorted_priority_queue_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_priority_queue_tb
// Streams enqueue/dequeue commands into the priority queue and checks every
// result transfer (byte, fill level, status) against a sorted-list model kept
// in the bench. Random stalls on both sides, one long output stall and one
// full drain pause; the final stretch runs at full rate.
// ----------------------------------------------------------------------------
module sorted_priority_queue_tb;

    localparam int CLK_HALF   = 6;
    localparam int CYCLE_CAP  = 200000;
    localparam int CHUNK_LEN  = 40;
    localparam int IDLE_CHUNKS = 25;
    localparam int CALM_CHUNKS = 3;
    localparam int HOLD_AFTER = 300;
    localparam int HOLD_LEN   = 120;

    typedef struct packed {
        spq_pkg::opcode_t           op;
        logic [spq_pkg::PRIO_W-1:0] prio;
        logic [spq_pkg::BYTE_W-1:0] tbyte;
    } queue_cmd_t;

    typedef struct packed {
        logic [spq_pkg::BYTE_W-1:0] out_byte;
        spq_pkg::status_t           status;
        logic [spq_pkg::FILL_W-1:0] fill;
    } queue_resp_t;

    logic        aclk;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;
    logic [0:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;

    queue_cmd_t  cmd_queue[$];
    queue_resp_t awaited_results[$];
    queue_cmd_t  cur_cmd = '0;
    int unsigned send_gap = 0;
    int unsigned accepted_cnt = 0;
    int unsigned issued_cnt = 0;
    int unsigned results_seen = 0;
    int unsigned stall_left = 0;
    logic        hold_done = 1'b0;
    logic        calm = 1'b0;
    int unsigned err_count = 0;
    int unsigned cycle_cnt = 0;

    logic [spq_pkg::PRIO_W-1:0] held_prio [spq_pkg::CAPACITY];
    logic [spq_pkg::BYTE_W-1:0] held_byte [spq_pkg::CAPACITY];
    int unsigned                held_count = 0;

    assign s_axis_tdata = {cur_cmd.tbyte, cur_cmd.prio};
    assign s_axis_tuser = cur_cmd.op;

    sorted_priority_queue u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        aclk = 1'b0;
        #CLK_HALF;
        aclk = 1'b1;
        #CLK_HALF;
    end

    // Sorted list: insert behind all entries of greater or equal priority.
    function automatic queue_resp_t predict_queue_op(queue_cmd_t cmd);
        queue_resp_t resp;
        int unsigned pos;
        resp = '0;
        resp.status = spq_pkg::ST_OK;
        if (cmd.op == spq_pkg::OP_ENQ) begin
            if (held_count >= spq_pkg::CAPACITY) begin
                resp.status = spq_pkg::ST_FULL;
            end else begin
                pos = 0;
                while (pos < held_count && held_prio[pos] >= cmd.prio) pos++;
                for (int k = held_count; k > pos; k--) begin
                    held_prio[k] = held_prio[k-1];
                    held_byte[k] = held_byte[k-1];
                end
                held_prio[pos] = cmd.prio;
                held_byte[pos] = cmd.tbyte;
                held_count++;
            end
        end else begin
            if (held_count == 0) begin
                resp.status = spq_pkg::ST_EMPTY;
            end else begin
                resp.out_byte = held_byte[0];
                for (int k = 1; k < held_count; k++) begin
                    held_prio[k-1] = held_prio[k];
                    held_byte[k-1] = held_byte[k];
                end
                held_count--;
            end
        end
        resp.fill = held_count[spq_pkg::FILL_W-1:0];
        return resp;
    endfunction

    // Sender: holds the offered command until the transfer, then idles or loads the next.
    always @(posedge aclk) begin
        logic        fire;
        logic        nxt_valid;
        queue_cmd_t  nxt_cmd;
        int unsigned nxt_gap;
        fire      = s_axis_tvalid && s_axis_tready;
        nxt_valid = s_axis_tvalid;
        nxt_cmd   = cur_cmd;
        nxt_gap   = send_gap;
        if (!aresetn) begin
            nxt_valid = 1'b0;
            nxt_gap   = 0;
        end else begin
            if (fire) begin
                awaited_results.push_back(predict_queue_op(cur_cmd));
                accepted_cnt <= accepted_cnt + 1;
            end
            if (!s_axis_tvalid || fire) begin
                nxt_valid = 1'b0;
                if (send_gap != 0) begin
                    nxt_gap = send_gap - 1;
                end else if (cmd_queue.size() != 0) begin
                    if (!calm && $urandom_range(0, 7) == 0) begin
                        nxt_gap = $urandom_range(0, 4);
                    end else begin
                        nxt_cmd   = cmd_queue.pop_front();
                        nxt_valid = 1'b1;
                    end
                end
            end
        end
        s_axis_tvalid <= nxt_valid;
        cur_cmd       <= nxt_cmd;
        send_gap      <= nxt_gap;
    end

    // Receiver: random short stalls plus one long hold to back up the input.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
            stall_left    <= 0;
        end else if (!hold_done && accepted_cnt >= HOLD_AFTER) begin
            hold_done     <= 1'b1;
            stall_left    <= HOLD_LEN - 1;
            m_axis_tready <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
            stall_left    <= $urandom_range(0, 4);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        queue_resp_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            results_seen++;
            if (awaited_results.size() == 0) begin
                $error("unexpected result transfer: byte %0d status %0d fill %0d",
                       m_axis_tdata[7:0], m_axis_tuser, m_axis_tdata[12:8]);
                err_count++;
            end else begin
                want = awaited_results.pop_front();
                if (m_axis_tdata[7:0] !== want.out_byte) begin
                    $error("out_byte: expected %0d, got %0d", want.out_byte,
                           m_axis_tdata[7:0]);
                    err_count++;
                end
                if (m_axis_tuser !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_axis_tuser);
                    err_count++;
                end
                if (m_axis_tdata[12:8] !== want.fill) begin
                    $error("fill_level: expected %0d, got %0d", want.fill,
                           m_axis_tdata[12:8]);
                    err_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_CAP) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic push_cmd(spq_pkg::opcode_t op, logic [spq_pkg::PRIO_W-1:0] prio,
                            logic [spq_pkg::BYTE_W-1:0] tbyte);
        queue_cmd_t cmd;
        cmd.op    = op;
        cmd.prio  = prio;
        cmd.tbyte = tbyte;
        cmd_queue.push_back(cmd);
        issued_cnt++;
    endtask

    task automatic push_random_cmd(int unsigned enq_pct);
        spq_pkg::opcode_t           op;
        logic [spq_pkg::PRIO_W-1:0] prio;
        op = ($urandom_range(0, 99) < enq_pct) ? spq_pkg::OP_ENQ : spq_pkg::OP_DEQ;
        case ($urandom_range(0, 3))
            0: prio = spq_pkg::PRIO_W'($urandom_range(0, 3));
            1: prio = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            default: prio = spq_pkg::PRIO_W'($urandom_range(0, 255));
        endcase
        push_cmd(op, prio, spq_pkg::BYTE_W'($urandom_range(0, 255)));
    endtask

    task automatic wait_drained();
        while (results_seen != issued_cnt) @(posedge aclk);
    endtask

    initial begin
        int unsigned enq_pct;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // empty dequeue, extremes, equal priorities, fill to capacity, full enqueue
        push_cmd(spq_pkg::OP_DEQ, 8'hFF, 8'hFF);
        push_cmd(spq_pkg::OP_ENQ, 8'h00, 8'h00);
        push_cmd(spq_pkg::OP_ENQ, 8'hFF, 8'hFF);
        push_cmd(spq_pkg::OP_ENQ, 8'h80, 8'hAA);
        push_cmd(spq_pkg::OP_ENQ, 8'h80, 8'h55);
        push_cmd(spq_pkg::OP_ENQ, 8'h80, 8'h01);
        push_cmd(spq_pkg::OP_ENQ, 8'hFF, 8'h02);
        push_cmd(spq_pkg::OP_ENQ, 8'h00, 8'h03);
        for (int i = 0; i < spq_pkg::CAPACITY - 7; i++) begin
            push_cmd(spq_pkg::OP_ENQ, spq_pkg::PRIO_W'(8'h40 + i),
                     spq_pkg::BYTE_W'(8'h10 + i));
        end
        push_cmd(spq_pkg::OP_ENQ, 8'hFF, 8'hEE);
        push_cmd(spq_pkg::OP_DEQ, 8'h00, 8'h00);
        push_cmd(spq_pkg::OP_DEQ, 8'h00, 8'h00);
        push_cmd(spq_pkg::OP_DEQ, 8'h00, 8'h00);
        wait_drained();

        for (int c = 0; c < IDLE_CHUNKS; c++) begin
            case ($urandom_range(0, 3))
                0: enq_pct = 10;
                1: enq_pct = 50;
                2: enq_pct = 75;
                default: enq_pct = 95;
            endcase
            for (int i = 0; i < CHUNK_LEN; i++) push_random_cmd(enq_pct);
        end
        while (cmd_queue.size() != 0) @(posedge aclk);
        calm = 1'b1;
        for (int c = 0; c < CALM_CHUNKS; c++) begin
            enq_pct = (c == 1) ? 90 : 40;
            for (int i = 0; i < CHUNK_LEN; i++) push_random_cmd(enq_pct);
        end

        wait_drained();
        repeat (4) @(posedge aclk);
        if (awaited_results.size() != 0) begin
            $error("%0d results never arrived", awaited_results.size());
            err_count++;
        end
        if (err_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
